[design/voice_slot_allocator_top_macros.svh]
// Assertion macros shared by the voice slot allocator.
`ifndef VOICE_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define VOICE_SLOT_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("voice slot allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define VSA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("voice slot allocator check failed");

`endif

[design/vsa_pkg.sv]
package vsa_pkg;

    localparam int unsigned VOICE_SLOTS = 32;
    localparam int unsigned SOUND_COUNT = 64;
    localparam int unsigned SLOT_W      = $clog2(VOICE_SLOTS);

    typedef enum logic [2:0] {
        REQ_PLAY     = 3'd0,
        REQ_STOP     = 3'd1,
        REQ_QUERY    = 3'd2,
        REQ_SET_LOUD = 3'd3,
        REQ_ENDED    = 3'd4,
        REQ_STOP_ALL = 3'd5
    } req_e_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic gen_read;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

[design/vsa_ctrl.sv]
module vsa_ctrl import vsa_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = status.need_scan ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_DECODE: begin
                cmd.gen_read = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_FINISH: begin
                cmd.commit = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[design/vsa_datapath.sv]
module vsa_datapath import vsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [2:0]  s_req_type,
    input  logic [4:0]  s_slot_index,
    input  logic [31:0] s_handle_generation,
    input  logic [7:0]  s_sound_id,
    input  logic        s_looping,
    input  logic [15:0] s_loudness,
    input  logic        s_stop_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [4:0]  m_granted_slot,
    output logic [31:0] m_granted_generation,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic [2:0]  req_type_reg;
    logic [4:0]  slot_index_reg;
    logic [31:0] handle_gen_reg;
    logic [7:0]  sound_id_reg;
    logic        looping_in_reg;
    logic [15:0] loudness_reg;
    logic        stop_now_reg;

    logic                   engine_running_reg;
    logic [VOICE_SLOTS-1:0] active_reg;
    logic [VOICE_SLOTS-1:0] active_next;
    logic [VOICE_SLOTS-1:0] looping_reg;
    logic [VOICE_SLOTS-1:0] looping_next;
    logic [31:0]            next_gen_reg;
    logic [31:0]            next_gen_next;

    logic [31:0] gen_mem  [VOICE_SLOTS];
    logic [15:0] loud_mem [VOICE_SLOTS];
    logic [31:0] gen_rd_reg;
    logic [15:0] loud_rd_reg;

    logic [SLOT_W-1:0] scan_cnt_reg;
    logic              eval_vld_reg;
    logic [SLOT_W-1:0] eval_idx_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic              best_found_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [15:0]       best_loud_reg;

    logic        m_valid_reg;
    logic        m_ok_reg;
    logic [4:0]  m_slot_reg;
    logic [31:0] m_gen_reg;

    logic [SLOT_W-1:0] addr_slot;
    logic              in_range;
    logic              handle_ok;
    logic              play_go;
    logic              play_ok;
    logic [SLOT_W-1:0] play_slot;
    logic              take_free;
    logic              take_best;
    logic              res_ok;
    logic              gen_we;
    logic              loud_we;
    logic [SLOT_W-1:0] loud_waddr;

    assign addr_slot = SLOT_W'(slot_index_reg);
    assign in_range  = 32'(slot_index_reg) < VOICE_SLOTS;
    assign handle_ok = in_range && active_reg[addr_slot] && (gen_rd_reg == handle_gen_reg);
    assign play_go   = (req_type_reg == REQ_PLAY) && engine_running_reg
                       && (32'(sound_id_reg) < SOUND_COUNT);
    assign play_ok   = play_go && (free_found_reg || best_found_reg);
    assign play_slot = free_found_reg ? free_slot_reg : best_slot_reg;

    assign take_free = eval_vld_reg && !free_found_reg && !active_reg[eval_idx_reg];
    assign take_best = eval_vld_reg && !looping_reg[eval_idx_reg]
                       && (!best_found_reg || (loud_rd_reg < best_loud_reg));

    assign status.need_scan = play_go;
    assign status.scan_last = scan_cnt_reg == SLOT_W'(VOICE_SLOTS - 1);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign cfg_ready            = 1'b1;
    assign m_valid              = m_valid_reg;
    assign m_ok                 = m_ok_reg;
    assign m_granted_slot       = m_slot_reg;
    assign m_granted_generation = m_gen_reg;

    always_comb begin
        active_next   = active_reg;
        looping_next  = looping_reg;
        next_gen_next = next_gen_reg;
        res_ok        = 1'b0;
        gen_we        = 1'b0;
        loud_we       = 1'b0;
        loud_waddr    = addr_slot;
        case (req_type_reg)
            REQ_PLAY: begin
                if (play_ok) begin
                    res_ok                  = 1'b1;
                    active_next[play_slot]  = 1'b1;
                    looping_next[play_slot] = looping_in_reg;
                    next_gen_next           = next_gen_reg + 32'd1;
                    gen_we                  = 1'b1;
                    loud_we                 = 1'b1;
                    loud_waddr              = play_slot;
                end
            end
            REQ_STOP: begin
                res_ok = handle_ok;
                if (handle_ok && stop_now_reg) begin
                    active_next[addr_slot] = 1'b0;
                end
            end
            REQ_QUERY: begin
                res_ok = handle_ok;
            end
            REQ_SET_LOUD: begin
                res_ok  = handle_ok;
                loud_we = handle_ok;
            end
            REQ_ENDED: begin
                if (in_range && active_reg[addr_slot]) begin
                    res_ok                 = 1'b1;
                    active_next[addr_slot] = 1'b0;
                end
            end
            REQ_STOP_ALL: begin
                res_ok      = 1'b1;
                active_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            engine_running_reg <= 1'b1;
            active_reg         <= '0;
            looping_reg        <= '0;
            next_gen_reg       <= 32'd1;
            eval_vld_reg       <= 1'b0;
            free_found_reg     <= 1'b0;
            best_found_reg     <= 1'b0;
            scan_cnt_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                engine_running_reg <= cfg_data;
            end
            eval_vld_reg <= cmd.scan_step;
            if (cmd.scan_step) begin
                scan_cnt_reg <= scan_cnt_reg + SLOT_W'(1);
            end
            if (cmd.capture) begin
                scan_cnt_reg   <= '0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end else begin
                if (take_free) begin
                    free_found_reg <= 1'b1;
                end
                if (take_best) begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                active_reg   <= active_next;
                looping_reg  <= looping_next;
                next_gen_reg <= next_gen_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg   <= s_req_type;
            slot_index_reg <= s_slot_index;
            handle_gen_reg <= s_handle_generation;
            sound_id_reg   <= s_sound_id;
            looping_in_reg <= s_looping;
            loudness_reg   <= s_loudness;
            stop_now_reg   <= s_stop_now;
        end
        if (cmd.scan_step) begin
            eval_idx_reg <= scan_cnt_reg;
        end
        if (take_free) begin
            free_slot_reg <= eval_idx_reg;
        end
        if (take_best) begin
            best_slot_reg <= eval_idx_reg;
            best_loud_reg <= loud_rd_reg;
        end
        if (cmd.commit) begin
            m_ok_reg   <= res_ok;
            m_slot_reg <= play_ok ? 5'(play_slot) : 5'd0;
            m_gen_reg  <= play_ok ? next_gen_reg : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.gen_read) begin
            gen_rd_reg <= gen_mem[addr_slot];
        end
        if (cmd.commit && gen_we) begin
            gen_mem[play_slot] <= next_gen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            loud_rd_reg <= loud_mem[scan_cnt_reg];
        end
        if (cmd.commit && loud_we) begin
            loud_mem[loud_waddr] <= loudness_reg;
        end
    end

endmodule

[design/voice_slot_allocator_top.sv]
// Voice slot allocator: a table of 32 voice slots with generation-tagged handles.
// Requests enter on the s_ channel (valid/ready); each gives exactly one result
// transaction on the m_ channel (ok, granted slot, granted generation).
// The cfg channel writes the engine running bit; it is always ready. The user must
// write it only while no request is in flight; the block does not enforce this.
// A play request with the engine running and a sound id in range scans every slot
// through the loudness memory, one slot per cycle, to find the lowest free slot
// and the quietest non-looping one. Other requests read the handle's generation
// from memory once and skip the scan.
// One request is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even if it was not yet taken.
// If the receiver stalls, a finished result waits until the output register
// is free, and no further request is accepted meanwhile.
// Reset (aresetn low, synchronous) frees every slot, sets the generation counter
// to one and the engine running bit to one; no clearing pass is needed.
`include "voice_slot_allocator_top_macros.svh"

module voice_slot_allocator_top import vsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [4:0]  s_slot_index,
    input  logic [31:0] s_handle_generation,
    input  logic [7:0]  s_sound_id,
    input  logic        s_looping,
    input  logic [15:0] s_loudness,
    input  logic        s_stop_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [4:0]  m_granted_slot,
    output logic [31:0] m_granted_generation,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    cmd_t    cmd;
    status_t status;

    vsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vsa_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .s_req_type           (s_req_type),
        .s_slot_index         (s_slot_index),
        .s_handle_generation  (s_handle_generation),
        .s_sound_id           (s_sound_id),
        .s_looping            (s_looping),
        .s_loudness           (s_loudness),
        .s_stop_now           (s_stop_now),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_ok                 (m_ok),
        .m_granted_slot       (m_granted_slot),
        .m_granted_generation (m_granted_generation),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data)
    );

    `VSA_ASSERT_NEXT(a_accept_blocks, aclk, aresetn, s_valid && s_ready, !s_ready)
    `VSA_ASSERT_SAME(a_commit_free, aclk, aresetn, cmd.commit, !m_valid || m_ready)
    `VSA_ASSERT_NEXT(a_commit_shows, aclk, aresetn, cmd.commit, m_valid)
    `VSA_ASSERT_SAME(a_scan_busy, aclk, aresetn, cmd.scan_step, !s_ready && !cmd.commit)

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import vsa_pkg::*;

    localparam int unsigned QUIET_LIMIT = 3000;

    typedef struct packed {
        logic        hold;
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic [31:0] gen;
        logic [7:0]  sound;
        logic        loops;
        logic [15:0] loud;
        logic        stop_now;
    } voice_req_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  slot;
        logic [31:0] gen;
    } voice_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type = '0;
    logic [4:0]  s_slot_index = '0;
    logic [31:0] s_handle_generation = '0;
    logic [7:0]  s_sound_id = '0;
    logic        s_looping = 1'b0;
    logic [15:0] s_loudness = '0;
    logic        s_stop_now = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic [4:0]  m_granted_slot;
    logic [31:0] m_granted_generation;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b1;

    // Shadow copy of the voice table, advanced on every accepted request.
    logic        engine_on = 1'b1;
    logic        voice_active [VOICE_SLOTS] = '{default: 1'b0};
    logic        voice_loops [VOICE_SLOTS] = '{default: 1'b0};
    logic [31:0] voice_gen [VOICE_SLOTS] = '{default: 32'd0};
    logic [15:0] voice_loud [VOICE_SLOTS] = '{default: 16'd0};
    logic [31:0] gen_counter = 32'd1;

    voice_req_t    pending_reqs [$];
    voice_result_t expected_results [$];
    voice_req_t    cur_req;
    voice_result_t want_res;
    int unsigned   sent_count = 0;
    int unsigned   got_count = 0;
    int unsigned   stim_count = 0;
    int unsigned   fail_count = 0;
    int unsigned   gap_left = 0;
    int unsigned   stall_left = 0;
    int unsigned   quiet_cycles = 0;
    bit            src_calm = 1'b0;
    bit            snk_calm = 1'b0;

    voice_slot_allocator_top uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_req_type           (s_req_type),
        .s_slot_index         (s_slot_index),
        .s_handle_generation  (s_handle_generation),
        .s_sound_id           (s_sound_id),
        .s_looping            (s_looping),
        .s_loudness           (s_loudness),
        .s_stop_now           (s_stop_now),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_ok                 (m_ok),
        .m_granted_slot       (m_granted_slot),
        .m_granted_generation (m_granted_generation),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic handle_live(logic [4:0] slot, logic [31:0] gen);
        return voice_active[slot] && voice_gen[slot] == gen;
    endfunction

    function automatic voice_result_t predict_voice(voice_req_t r);
        voice_result_t res;
        int            pick;
        int            i;
        logic [15:0]   best;
        res = '0;
        pick = -1;
        best = '0;
        case (r.kind)
            REQ_PLAY: begin
                if (engine_on && r.sound < SOUND_COUNT) begin
                    for (i = 0; i < VOICE_SLOTS; i++) begin
                        if (pick < 0 && !voice_active[i]) pick = i;
                    end
                    if (pick < 0) begin
                        for (i = 0; i < VOICE_SLOTS; i++) begin
                            if (!voice_loops[i] && (pick < 0 || voice_loud[i] < best)) begin
                                best = voice_loud[i];
                                pick = i;
                            end
                        end
                    end
                    if (pick >= 0) begin
                        voice_active[pick] = 1'b1;
                        voice_loops[pick] = r.loops;
                        voice_loud[pick] = r.loud;
                        voice_gen[pick] = gen_counter;
                        gen_counter = gen_counter + 32'd1;
                        res.ok = 1'b1;
                        res.slot = pick[4:0];
                        res.gen = voice_gen[pick];
                    end
                end
            end
            REQ_STOP: begin
                if (handle_live(r.slot, r.gen)) begin
                    res.ok = 1'b1;
                    if (r.stop_now) voice_active[r.slot] = 1'b0;
                end
            end
            REQ_QUERY: begin
                res.ok = handle_live(r.slot, r.gen);
            end
            REQ_SET_LOUD: begin
                if (handle_live(r.slot, r.gen)) begin
                    res.ok = 1'b1;
                    voice_loud[r.slot] = r.loud;
                end
            end
            REQ_ENDED: begin
                if (voice_active[r.slot]) begin
                    voice_active[r.slot] = 1'b0;
                    res.ok = 1'b1;
                end
            end
            REQ_STOP_ALL: begin
                for (i = 0; i < VOICE_SLOTS; i++) voice_active[i] = 1'b0;
                res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s at result %0d: got %0h, expected %0h",
                 field, got_count, got, want);
        fail_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned pct;
        pct = $urandom_range(0, 99);
        if (pct < 55) return 0;
        if (pct < 90) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_voice(cur_req));
                sent_count <= sent_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0 && !(pending_reqs[0].hold &&
                             (sent_count != got_count || (s_valid && s_ready)))) begin
                    cur_req = pending_reqs.pop_front();
                    s_req_type <= cur_req.kind;
                    s_slot_index <= cur_req.slot;
                    s_handle_generation <= cur_req.gen;
                    s_sound_id <= cur_req.sound;
                    s_looping <= cur_req.loops;
                    s_loudness <= cur_req.loud;
                    s_stop_now <= cur_req.stop_now;
                    s_valid <= 1'b1;
                    gap_left = src_calm ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (got_count == sent_count) begin
                    flag_mismatch("result with nothing expected", 32'(m_ok), 32'd0);
                end else begin
                    want_res = expected_results.pop_front();
                    if (m_ok !== want_res.ok)
                        flag_mismatch("ok", 32'(m_ok), 32'(want_res.ok));
                    if (m_granted_slot !== want_res.slot)
                        flag_mismatch("granted_slot", 32'(m_granted_slot),
                                      32'(want_res.slot));
                    if (m_granted_generation !== want_res.gen)
                        flag_mismatch("granted_generation", m_granted_generation, want_res.gen);
                    got_count <= got_count + 1;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!snk_calm && $urandom_range(0, 99) < 12) stall_left = pick_gap() + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic voice_req_t mk_req(logic [2:0] kind, logic [4:0] slot,
                                          logic [31:0] gen, logic [7:0] sound,
                                          logic loops, logic [15:0] loud, logic stop_now);
        voice_req_t r;
        r.hold = 1'b0;
        r.kind = kind;
        r.slot = slot;
        r.gen = gen;
        r.sound = sound;
        r.loops = loops;
        r.loud = loud;
        r.stop_now = stop_now;
        return r;
    endfunction

    function automatic voice_req_t random_request();
        voice_req_t  r;
        int unsigned pct;
        int unsigned tries;
        int unsigned c;
        r = mk_req(REQ_PLAY, 5'($urandom_range(0, 31)), $urandom,
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        pct = $urandom_range(0, 99);
        if (pct < 40) begin
            if ($urandom_range(0, 9) != 0) r.sound = 8'($urandom_range(0, SOUND_COUNT - 1));
            r.loops = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) != 0) r.loud = 16'($urandom_range(0, 7));
        end else if (pct < 95) begin
            if (pct < 55) r.kind = REQ_STOP;
            else if (pct < 65) r.kind = REQ_QUERY;
            else if (pct < 77) r.kind = REQ_SET_LOUD;
            else if (pct < 92) r.kind = REQ_ENDED;
            else r.kind = REQ_STOP_ALL;
            for (tries = 0; tries < 4 && !voice_active[r.slot]; tries++)
                r.slot = 5'($urandom_range(0, 31));
            c = $urandom_range(0, 19);
            if (c < 15) r.gen = voice_gen[r.slot];
            else if (c < 17) r.gen = voice_gen[r.slot] + 32'd1;
            else if (c < 18) r.gen = voice_gen[r.slot] - 32'd1;
        end else begin
            r.kind = 3'($urandom_range(0, 7));
        end
        return r;
    endfunction

    task automatic push_req(voice_req_t r);
        do @(negedge aclk); while (pending_reqs.size() >= 2);
        pending_reqs.push_back(r);
        if (r.kind <= REQ_STOP_ALL) stim_count++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || sent_count != got_count);
    endtask

    task automatic write_engine(logic val);
        wait_drained();
        repeat (40) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        engine_on = val;
        cfg_valid <= 1'b0;
    endtask

    // Fills the table with plays so that stealing, loudness ties and the
    // all-looping refusal are reached.
    task automatic fill_burst();
        voice_req_t  r;
        int unsigned mode;
        int          k;
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 1) != 0) begin
            r = random_request();
            r.kind = REQ_STOP_ALL;
            push_req(r);
        end
        for (k = 0; k < 36; k++) begin
            r = random_request();
            r.kind = REQ_PLAY;
            r.hold = 1'b0;
            r.sound = 8'($urandom_range(0, SOUND_COUNT - 1));
            r.loops = (mode == 2) || (mode == 1 && $urandom_range(0, 1) == 1);
            r.loud = 16'($urandom_range(0, 3) << 8);
            push_req(r);
        end
    endtask

    task automatic run_random(int unsigned n);
        voice_req_t  r;
        int unsigned stop_at;
        bit          first;
        stop_at = stim_count + n;
        first = 1'b1;
        while (stim_count < stop_at) begin
            if ($urandom_range(0, 99) == 0) begin
                src_calm = ($urandom_range(0, 2) == 0);
                snk_calm = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 59) == 0) begin
                fill_burst();
            end else begin
                r = random_request();
                r.hold = first || ($urandom_range(0, 99) == 0);
                first = 1'b0;
                push_req(r);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        push_req(mk_req(REQ_PLAY, 5'd0, 32'd0, 8'd0, 1'b0, 16'h0000, 1'b0));
        push_req(mk_req(REQ_PLAY, 5'd31, 32'hFFFFFFFF, 8'(SOUND_COUNT - 1), 1'b1, 16'hFFFF,
                        1'b1));
        push_req(mk_req(REQ_PLAY, 5'd0, 32'd0, 8'(SOUND_COUNT), 1'b0, 16'h0100, 1'b0));
        push_req(mk_req(REQ_PLAY, 5'd0, 32'd0, 8'hFF, 1'b0, 16'h0100, 1'b0));
        push_req(mk_req(REQ_QUERY, 5'd0, 32'd1, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(REQ_QUERY, 5'd0, 32'hFFFFFFFF, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(REQ_SET_LOUD, 5'd1, 32'd2, 8'd0, 1'b0, 16'h1234, 1'b0));
        push_req(mk_req(REQ_STOP, 5'd1, 32'd2, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(REQ_QUERY, 5'd1, 32'd2, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(REQ_ENDED, 5'd1, 32'd0, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(REQ_ENDED, 5'd1, 32'd0, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(REQ_STOP, 5'd0, 32'd1, 8'd0, 1'b0, 16'd0, 1'b1));
        push_req(mk_req(REQ_QUERY, 5'd0, 32'd1, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(3'd6, 5'd0, 32'd1, 8'd0, 1'b0, 16'd0, 1'b1));
        push_req(mk_req(3'd7, 5'd31, 32'hFFFFFFFF, 8'hFF, 1'b1, 16'hFFFF, 1'b1));
        push_req(mk_req(REQ_PLAY, 5'd0, 32'd0, 8'd5, 1'b0, 16'h4000, 1'b0));
        push_req(mk_req(REQ_STOP_ALL, 5'd0, 32'd0, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(REQ_ENDED, 5'd31, 32'd0, 8'd0, 1'b0, 16'd0, 1'b0));
        push_req(mk_req(REQ_QUERY, 5'd0, 32'd3, 8'd0, 1'b0, 16'd0, 1'b0));

        write_engine(1'b0);
        run_random(120);
        write_engine(1'b1);
        run_random(1400);
        write_engine(1'b0);
        run_random(60);
        write_engine(1'b1);
        run_random(70);

        wait_drained();
        repeat (60) @(posedge aclk);
        if (expected_results.size() != 0)
            flag_mismatch("results never delivered", 32'd0, 32'(expected_results.size()));
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
